/* hw/rtl/pphd_pkg.sv */
package pphd_pkg;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
    } point_t;

    typedef struct packed {
        logic signed [31:0] pixel_u;
        logic signed [31:0] pixel_v;
        logic               projection_valid;
    } pixel_t;

    localparam int CFG_ADDR_W = 6;
    localparam int CFG_DATA_W = 64;

    localparam logic [2:0] REG_FOCAL_X    = 3'd0;
    localparam logic [2:0] REG_FOCAL_Y    = 3'd1;
    localparam logic [2:0] REG_CENTER_X   = 3'd2;
    localparam logic [2:0] REG_CENTER_Y   = 3'd3;
    localparam logic [2:0] REG_RADIAL_K1  = 3'd4;
    localparam logic [2:0] REG_RADIAL_K2  = 3'd5;
    localparam logic [2:0] REG_RADIAL_K3  = 3'd6;
    localparam logic [2:0] REG_TANGENTIAL = 3'd7;

    localparam logic [31:0] FOCAL_X_RST  = 32'd170324784;
    localparam logic [31:0] FOCAL_Y_RST  = 32'd170324784;
    localparam logic [31:0] CENTER_X_RST = 32'd302252032;
    localparam logic [31:0] CENTER_Y_RST = 32'd109576192;

    localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;
    localparam logic signed [63:0] ONE_Q32 = 64'sh0000_0001_0000_0000;
    localparam logic signed [63:0] S32_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] S32_MIN = 64'shFFFF_FFFF_8000_0000;

    // Saturating signed 64-bit add.
    function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s[64] != s[63])
        begin
            return s[64] ? S64_MIN : S64_MAX;
        end
        return s[63:0];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > S32_MAX)
        begin
            return S32_MAX[31:0];
        end
        if (v < S32_MIN)
        begin
            return S32_MIN[31:0];
        end
        return v[31:0];
    endfunction

endpackage

/* hw/rtl/pphd_dly.sv */
module pphd_dly #(
    parameter int W = 64,
    parameter int N = 1
) (
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);
    logic [W-1:0] tap_reg [0:N-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tap_reg[0] <= d;
            for (int i = 1; i < N; i++)
            begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign q = tap_reg[N-1];
endmodule

/* hw/rtl/pphd_smul.sv */
module pphd_smul #(
    parameter int SH = 32
) (
    input  logic               clk,
    input  logic               en,
    input  logic signed [63:0] a,
    input  logic signed [63:0] b,
    output logic signed [63:0] y
);
    import pphd_pkg::*;

    // Split each operand into a signed high word and an unsigned low word.
    logic        [31:0]  al, bl;
    logic signed [31:0]  ah, bh;
    logic        [63:0]  ll_next, ll_reg, ll2_reg;
    logic signed [64:0]  lh_next, hl_next, lh_reg, hl_reg;
    logic signed [63:0]  hh_next, hh_reg, hh2_reg;
    logic signed [65:0]  mid_reg;
    logic        [127:0] full;
    logic        [127-SH-63:0] top;
    logic                fits;
    logic signed [63:0]  y_next, y_reg;

    assign al = a[31:0];
    assign bl = b[31:0];
    assign ah = a[63:32];
    assign bh = b[63:32];

    assign ll_next = al * bl;
    assign lh_next = $signed({1'b0, al}) * bh;
    assign hl_next = ah * $signed({1'b0, bl});
    assign hh_next = ah * bh;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ll_reg  <= ll_next;
            lh_reg  <= lh_next;
            hl_reg  <= hl_next;
            hh_reg  <= hh_next;
            mid_reg <= 66'(lh_reg) + 66'(hl_reg);
            ll2_reg <= ll_reg;
            hh2_reg <= hh_reg;
            y_reg   <= y_next;
        end
    end

    // Exact 128-bit product; the arithmetic shift gives the floor.
    always_comb
    begin
        full = {hh2_reg, 64'd0}
             + {{30{mid_reg[65]}}, mid_reg, 32'd0}
             + {64'd0, ll2_reg};
        top  = full[127:SH+63];
        fits = (&top) || !(|top);
        if (fits)
        begin
            y_next = full[SH+63:SH];
        end
        else
        begin
            y_next = full[127] ? S64_MIN : S64_MAX;
        end
    end

    assign y = y_reg;
endmodule

/* hw/rtl/pphd_div.sv */
module pphd_div (
    input  logic               clk,
    input  logic               en,
    input  logic [31:0]        num,
    input  logic               neg,
    input  logic [30:0]        den,
    output logic signed [63:0] quot
);
    localparam int STEPS = 64;

    // Restoring division of num * 2^32 by den, one quotient bit per stage.
    logic [30:0] rem_d [0:STEPS];
    logic [63:0] q_d   [0:STEPS];
    logic [31:0] nb_d  [0:STEPS];
    logic [30:0] den_d [0:STEPS];
    logic        neg_d [0:STEPS];

    logic [30:0] rem_reg [1:STEPS];
    logic [63:0] q_reg   [1:STEPS];
    logic [31:0] nb_reg  [1:STEPS];
    logic [30:0] den_reg [1:STEPS];
    logic        neg_reg [1:STEPS];
    logic [63:0] quot_reg;

    assign rem_d[0] = '0;
    assign q_d[0]   = '0;
    assign nb_d[0]  = num;
    assign den_d[0] = den;
    assign neg_d[0] = neg;

    for (genvar i = 0; i < STEPS; i++)
    begin : g_step
        logic [31:0] trial;
        logic [31:0] diff;
        logic        ge;

        assign trial = {rem_d[i], nb_d[i][31]};
        assign diff  = trial - {1'b0, den_d[i]};
        assign ge    = trial >= {1'b0, den_d[i]};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i+1] <= ge ? diff[30:0] : trial[30:0];
                q_reg[i+1]   <= {q_d[i][62:0], ge};
                nb_reg[i+1]  <= {nb_d[i][30:0], 1'b0};
                den_reg[i+1] <= den_d[i];
                neg_reg[i+1] <= neg_d[i];
            end
        end

        assign rem_d[i+1] = rem_reg[i+1];
        assign q_d[i+1]   = q_reg[i+1];
        assign nb_d[i+1]  = nb_reg[i+1];
        assign den_d[i+1] = den_reg[i+1];
        assign neg_d[i+1] = neg_reg[i+1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quot_reg <= neg_d[STEPS] ? (64'd0 - q_d[STEPS]) : q_d[STEPS];
        end
    end

    assign quot = $signed(quot_reg);
endmodule

/* hw/rtl/pinhole_projection_with_distortion.sv */
// Pinhole camera projection with radial and tangential lens distortion.
//
// Points enter on the point channel (point_valid, point_stall, point) and
// pixels leave on the pixel channel (pixel_valid, pixel_stall, pixel). Every
// point gives exactly one pixel beat, in order. A point with non-positive
// depth gives a beat with projection_valid low and zero coordinates.
//
// A new point can be taken in every cycle while point_stall is low. The
// delay from a point to its pixel is set by the 64-stage quotient pipeline,
// one bit per stage, followed by the chain of six pipelined multiplies of
// three stages each and their saturating adds.
//
// When the receiver stalls, the pending pixel holds and one further pixel
// is caught in a skid register; only then does the whole pipeline freeze
// and point_stall rise. Reset empties the pipeline and loads the register
// defaults. Lens registers are written over the APB port at byte address
// 8 * index and must only change while no point is in flight.
module pinhole_projection_with_distortion (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            point_valid,
    output logic                            point_stall,
    input  pphd_pkg::point_t                point,
    output logic                            pixel_valid,
    input  logic                            pixel_stall,
    output pphd_pkg::pixel_t                pixel,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pphd_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [pphd_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [pphd_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready
);
    import pphd_pkg::*;

    localparam int DIV_LAT  = 65;
    localparam int TAIL_LAT = 23;
    localparam int META_LAT = DIV_LAT + TAIL_LAT;

    // Configuration registers.
    logic        [31:0] focal_x_reg, focal_y_reg;
    logic signed [31:0] center_x_reg, center_y_reg;
    logic signed [31:0] radial_k1_reg, radial_k2_reg, radial_k3_reg;
    logic        [63:0] tangential_reg;
    logic        [2:0]  cfg_idx;

    assign cfg_idx = paddr[5:3];
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focal_x_reg    <= FOCAL_X_RST;
            focal_y_reg    <= FOCAL_Y_RST;
            center_x_reg   <= CENTER_X_RST;
            center_y_reg   <= CENTER_Y_RST;
            radial_k1_reg  <= '0;
            radial_k2_reg  <= '0;
            radial_k3_reg  <= '0;
            tangential_reg <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            case (cfg_idx)
                REG_FOCAL_X:    focal_x_reg    <= pwdata[31:0];
                REG_FOCAL_Y:    focal_y_reg    <= pwdata[31:0];
                REG_CENTER_X:   center_x_reg   <= pwdata[31:0];
                REG_CENTER_Y:   center_y_reg   <= pwdata[31:0];
                REG_RADIAL_K1:  radial_k1_reg  <= pwdata[31:0];
                REG_RADIAL_K2:  radial_k2_reg  <= pwdata[31:0];
                REG_RADIAL_K3:  radial_k3_reg  <= pwdata[31:0];
                REG_TANGENTIAL: tangential_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_FOCAL_X:    prdata = {32'd0, focal_x_reg};
            REG_FOCAL_Y:    prdata = {32'd0, focal_y_reg};
            REG_CENTER_X:   prdata = {32'd0, center_x_reg};
            REG_CENTER_Y:   prdata = {32'd0, center_y_reg};
            REG_RADIAL_K1:  prdata = {32'd0, radial_k1_reg};
            REG_RADIAL_K2:  prdata = {32'd0, radial_k2_reg};
            REG_RADIAL_K3:  prdata = {32'd0, radial_k3_reg};
            REG_TANGENTIAL: prdata = tangential_reg;
            default:        prdata = '0;
        endcase
    end

    logic signed [63:0] k1, k2, k3, p1, p2, fx, fy, cx, cy;

    assign k1 = 64'(radial_k1_reg);
    assign k2 = 64'(radial_k2_reg);
    assign k3 = 64'(radial_k3_reg);
    assign p1 = 64'($signed(tangential_reg[31:0]));
    assign p2 = 64'($signed(tangential_reg[63:32]));
    assign fx = $signed({32'd0, focal_x_reg});
    assign fy = $signed({32'd0, focal_y_reg});
    assign cx = 64'(center_x_reg);
    assign cy = 64'(center_y_reg);

    // Pipeline advance: everything moves unless the skid register is full.
    logic skid_full_reg;
    logic en;

    assign en          = !skid_full_reg;
    assign point_stall = skid_full_reg;

    // Input stage.
    logic [31:0]       mag_x_reg, mag_y_reg;
    logic [30:0]       den_reg;
    logic              neg_x_reg, neg_y_reg, pos_reg;
    logic [META_LAT:0] vld_reg;
    logic              pos_in;

    assign pos_in = !point.point_z[31] && (point.point_z != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[META_LAT-1:0], point_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_x_reg <= point.point_x[31] ? (32'd0 - point.point_x) : point.point_x;
            mag_y_reg <= point.point_y[31] ? (32'd0 - point.point_y) : point.point_y;
            // A non-positive depth is replaced by one; its result is discarded.
            den_reg   <= pos_in ? point.point_z[30:0] : 31'd1;
            neg_x_reg <= point.point_x[31];
            neg_y_reg <= point.point_y[31];
            pos_reg   <= pos_in;
        end
    end

    logic signed [63:0] xn, yn;

    pphd_div u_div_x (
        .clk (clk), .en (en), .num (mag_x_reg), .neg (neg_x_reg), .den (den_reg),
        .quot (xn)
    );
    pphd_div u_div_y (
        .clk (clk), .en (en), .num (mag_y_reg), .neg (neg_y_reg), .den (den_reg),
        .quot (yn)
    );

    // Squares and cross term.
    logic signed [63:0] x2, y2, xy;

    pphd_smul #(.SH(32)) u_x2 (.clk(clk), .en(en), .a(xn), .b(xn), .y(x2));
    pphd_smul #(.SH(32)) u_y2 (.clk(clk), .en(en), .a(yn), .b(yn), .y(y2));
    pphd_smul #(.SH(32)) u_xy (.clk(clk), .en(en), .a(xn), .b(yn), .y(xy));

    logic signed [63:0] r2_reg, x2d_reg, y2d_reg, tx_reg, ty_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r2_reg  <= sadd(x2, y2);
            x2d_reg <= sadd(x2, x2);
            y2d_reg <= sadd(y2, y2);
            tx_reg  <= sadd(r2_reg, x2d_reg);
            ty_reg  <= sadd(r2_reg, y2d_reg);
        end
    end

    // Radial powers and their coefficient products.
    logic signed [63:0] r4, r6, r2_t7, k1r2, k2r4, k3r6;

    pphd_smul #(.SH(32)) u_r4 (.clk(clk), .en(en), .a(r2_reg), .b(r2_reg), .y(r4));
    pphd_smul #(.SH(28)) u_k1 (.clk(clk), .en(en), .a(k1), .b(r2_reg), .y(k1r2));
    pphd_dly #(.W(64), .N(3)) d_r2 (.clk(clk), .en(en), .d(r2_reg), .q(r2_t7));
    pphd_smul #(.SH(32)) u_r6 (.clk(clk), .en(en), .a(r4), .b(r2_t7), .y(r6));
    pphd_smul #(.SH(28)) u_k2 (.clk(clk), .en(en), .a(k2), .b(r4), .y(k2r4));
    pphd_smul #(.SH(28)) u_k3 (.clk(clk), .en(en), .a(k3), .b(r6), .y(k3r6));

    // Radial gain, summed in the order 1 + k1 term + k2 term + k3 term.
    logic signed [63:0] k1r2_t10, k2r4_t11, kb_t13;
    logic signed [63:0] ka_reg, kb_reg, kr_reg;

    pphd_dly #(.W(64), .N(3)) d_k1 (.clk(clk), .en(en), .d(k1r2), .q(k1r2_t10));
    pphd_dly #(.W(64), .N(1)) d_k2 (.clk(clk), .en(en), .d(k2r4), .q(k2r4_t11));
    pphd_dly #(.W(64), .N(1)) d_kb (.clk(clk), .en(en), .d(kb_reg), .q(kb_t13));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ka_reg <= sadd(ONE_Q32, k1r2_t10);
            kb_reg <= sadd(ka_reg, k2r4_t11);
            kr_reg <= sadd(kb_t13, k3r6);
        end
    end

    logic signed [63:0] xn_t14, yn_t14, xnkr, ynkr;

    pphd_dly #(.W(64), .N(14)) d_xn (.clk(clk), .en(en), .d(xn), .q(xn_t14));
    pphd_dly #(.W(64), .N(14)) d_yn (.clk(clk), .en(en), .d(yn), .q(yn_t14));
    pphd_smul #(.SH(32)) u_xk (.clk(clk), .en(en), .a(xn_t14), .b(kr_reg), .y(xnkr));
    pphd_smul #(.SH(32)) u_yk (.clk(clk), .en(en), .a(yn_t14), .b(kr_reg), .y(ynkr));

    // Tangential terms; a shift of 27 doubles the cross-term product.
    logic signed [63:0] p1xy, p2xy, p2tx, p1ty;
    logic signed [63:0] p1xy_t17, p2xy_t18, p2tx_t18, p1ty_t17;

    pphd_smul #(.SH(27)) u_p1xy (.clk(clk), .en(en), .a(p1), .b(xy), .y(p1xy));
    pphd_smul #(.SH(27)) u_p2xy (.clk(clk), .en(en), .a(p2), .b(xy), .y(p2xy));
    pphd_smul #(.SH(28)) u_p2tx (.clk(clk), .en(en), .a(p2), .b(tx_reg), .y(p2tx));
    pphd_smul #(.SH(28)) u_p1ty (.clk(clk), .en(en), .a(p1), .b(ty_reg), .y(p1ty));
    pphd_dly #(.W(64), .N(11)) d_p1xy (.clk(clk), .en(en), .d(p1xy), .q(p1xy_t17));
    pphd_dly #(.W(64), .N(12)) d_p2xy (.clk(clk), .en(en), .d(p2xy), .q(p2xy_t18));
    pphd_dly #(.W(64), .N(10)) d_p2tx (.clk(clk), .en(en), .d(p2tx), .q(p2tx_t18));
    pphd_dly #(.W(64), .N(9))  d_p1ty (.clk(clk), .en(en), .d(p1ty), .q(p1ty_t17));

    logic signed [63:0] du1_reg, dv1_reg, du_reg, dv_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            du1_reg <= sadd(xnkr, p1xy_t17);
            dv1_reg <= sadd(ynkr, p1ty_t17);
            du_reg  <= sadd(du1_reg, p2tx_t18);
            dv_reg  <= sadd(dv1_reg, p2xy_t18);
        end
    end

    // Focal scaling and principal point.
    logic signed [63:0] fu, fv;
    logic signed [31:0] pu_reg, pv_reg;
    logic               pos_t23;

    pphd_smul #(.SH(32)) u_fu (.clk(clk), .en(en), .a(fx), .b(du_reg), .y(fu));
    pphd_smul #(.SH(32)) u_fv (.clk(clk), .en(en), .a(fy), .b(dv_reg), .y(fv));
    pphd_dly #(.W(1), .N(META_LAT)) d_pos (.clk(clk), .en(en), .d(pos_reg), .q(pos_t23));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pu_reg <= sat32(sadd(fu, cx));
            pv_reg <= sat32(sadd(fv, cy));
        end
    end

    pixel_t fin;

    always_comb
    begin
        fin = '0;
        if (pos_t23)
        begin
            fin.pixel_u          = pu_reg;
            fin.pixel_v          = pv_reg;
            fin.projection_valid = 1'b1;
        end
    end

    // Output register with one skid entry behind it.
    logic   pixel_valid_reg;
    pixel_t pixel_reg, skid_reg;
    logic   free, arrive;

    assign free   = !pixel_valid_reg || !pixel_stall;
    assign arrive = en && vld_reg[META_LAT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_valid_reg <= 1'b0;
            skid_full_reg   <= 1'b0;
        end
        else if (skid_full_reg)
        begin
            if (free)
            begin
                pixel_valid_reg <= 1'b1;
                skid_full_reg   <= 1'b0;
            end
        end
        else if (free)
        begin
            pixel_valid_reg <= arrive;
        end
        else if (arrive)
        begin
            skid_full_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_full_reg)
        begin
            if (free)
            begin
                pixel_reg <= skid_reg;
            end
        end
        else if (arrive)
        begin
            if (free)
            begin
                pixel_reg <= fin;
            end
            else
            begin
                skid_reg <= fin;
            end
        end
    end

    assign pixel_valid = pixel_valid_reg;
    assign pixel       = pixel_reg;
endmodule
